// ----- hw/rtl/quadratic_fit_limit_check_macros.svh -----
// Assertion macros for the quadratic fit limit checker.
// Used by the checker module; needs signals named clock and reset in scope.
`ifndef QUADRATIC_FIT_LIMIT_CHECK_MACROS_SVH
`define QUADRATIC_FIT_LIMIT_CHECK_MACROS_SVH

// property checked at every edge, reset included
`define QFLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// property checked outside reset
`define QFLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ----- hw/rtl/qflc_pkg.sv -----
// Types, constants and helper functions of the quadratic fit limit checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qflc_pkg;

   localparam int TIME_BITS_DEF = 20;
   localparam int SIZE_BITS_DEF = 20;
   localparam int FRAC_BITS_DEF = 32;

   localparam int TEST_NUM_W  = 16;
   localparam int ELAPSED_W   = 20;
   localparam int SIZE_FLD_W  = 20;
   localparam int COEF_W      = 64;
   localparam int IDS_W       = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 3 * COEF_W;
   localparam logic [COEF_W-1:0] TOL_LSB  = 64'd4;
   localparam logic [COEF_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   localparam logic OP_RECORD  = 1'b0;
   localparam logic OP_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_NO_DATA    = 2'd0,
      VERDICT_WITHIN     = 2'd1,
      VERDICT_EXCEEDED   = 2'd2,
      VERDICT_DEGENERATE = 2'd3
   } verdict_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TEST_IDS    = 3'd0,
      REG_SIZE_A      = 3'd1,
      REG_SIZE_B      = 3'd2,
      REG_SIZE_C      = 3'd3,
      REG_LIMIT_SQ    = 3'd4,
      REG_LIMIT_LIN   = 3'd5,
      REG_LIMIT_CONST = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_FACT, ST_MUL, ST_ACCUM, ST_DIVGO, ST_DIVW, ST_CMP
   } state_type;

   // factor codes: differences, sums and plain sizes
   typedef enum logic [3:0] {
      FC_D01, FC_D02, FC_D12, FC_S01, FC_S02, FC_S12, FC_X0, FC_X1, FC_X2
   } fcode_type;

   localparam logic [1:0] YSEL_ONE = 2'd3;

   // term 0 is the denominator; 1..3 squared, 4..6 linear, 7..9 constant
   localparam logic [3:0] TERM_DEN       = 4'd0;
   localparam logic [3:0] TERM_SQ_LAST   = 4'd3;
   localparam logic [3:0] TERM_LIN_LAST  = 4'd6;
   localparam logic [3:0] TERM_CONST_LAST = 4'd9;

   typedef struct packed {
      logic [1:0] ysel;
      logic [1:0] nfac;
      fcode_type  f0;
      fcode_type  f1;
      fcode_type  f2;
      logic       flip;
   } term_type;

   function automatic term_type term_info(input logic [3:0] t);
      term_type r;
      case (t)
         4'd1:    r = '{2'd0, 2'd1, FC_D12, FC_X0, FC_X0, 1'b0};
         4'd2:    r = '{2'd1, 2'd1, FC_D02, FC_X0, FC_X0, 1'b1};
         4'd3:    r = '{2'd2, 2'd1, FC_D01, FC_X0, FC_X0, 1'b0};
         4'd4:    r = '{2'd0, 2'd2, FC_D12, FC_S12, FC_X0, 1'b1};
         4'd5:    r = '{2'd1, 2'd2, FC_D02, FC_S02, FC_X0, 1'b0};
         4'd6:    r = '{2'd2, 2'd2, FC_D01, FC_S01, FC_X0, 1'b1};
         4'd7:    r = '{2'd0, 2'd3, FC_D12, FC_X1, FC_X2, 1'b0};
         4'd8:    r = '{2'd1, 2'd3, FC_D02, FC_X0, FC_X2, 1'b1};
         4'd9:    r = '{2'd2, 2'd3, FC_D01, FC_X0, FC_X1, 1'b0};
         default: r = '{YSEL_ONE, 2'd3, FC_D01, FC_D02, FC_D12, 1'b0};
      endcase
      return r;
   endfunction

   // compare from the squared term down with offset-binary coefficients
   function automatic logic limit_exceeded(input logic [2:0][COEF_W-1:0] fit,
                                           input logic [2:0][COEF_W-1:0] lim);
      logic             res;
      logic             hit;
      logic [COEF_W-1:0] fu;
      logic [COEF_W-1:0] lu;
      res = 1'b0;
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         fu = fit[k] ^ SIGN_BIT;
         lu = lim[k] ^ SIGN_BIT;
         if (!hit) begin
            if (fu > lu && (fu - lu) > TOL_LSB) begin
               res = 1'b1;
               hit = 1'b1;
            end else if (lu > fu && (lu - fu) > TOL_LSB) begin
               hit = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/qflc_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient built in place.
// Depends on qflc_pkg.
`timescale 1ns / 1ps

module qflc_div
   import qflc_pkg::*;
#(
   parameter int QW = 128,
   parameter int RW = 80
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW);

   logic [QW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] shifted;
   logic          fits;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[RW-2:0], dvd_ff[QW-1]};
      fits    = shifted >= divisor;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? shifted - divisor : shifted;
         dvd_in = {dvd_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- hw/rtl/quadratic_fit_limit_check.sv -----
// Top level of the quadratic fit limit checker: sample capture, fit sequencer
// with a shift-add multiplier, cached coefficients. Depends on qflc_pkg, qflc_div.
`timescale 1ns / 1ps
//
//  channel  | ports             | tdata / tuser
//  ---------+-------------------+------------------------------------------
//  request  | req_t*            | tuser op; tdata test_number, elapsed_time
//  response | rsp_t*            | tuser verdict_code; tdata fit_sq/lin/const
//  control  | csr_wen/addr/wdata| one register write per edge
//
// Records and verdicts without a fit run are handled in ST_IDLE; a verdict on a
// cached fit passes through ST_CMP. A first full fit runs the serial multiplier
// and the one-bit-a-cycle divider (QW=max(64,TIME_BITS+3*SIZE_BITS+FRAC_BITS+8));
// no item is taken meanwhile. Reset is synchronous and clears control, samples,
// fit and csr state (sizes to 0, 1, 2), not the datapath; a held response
// blocks new words until it is taken.

module quadratic_fit_limit_check
   import qflc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // test_number, elapsed_time, zero pad
   input  logic                  req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // fit_sq, fit_lin, fit_const
   output logic [1:0]            rsp_tuser,   // verdict_code
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FW  = SIZE_BITS + 1;
   localparam int VW  = TIME_BITS + 3 * FW;
   localparam int AW  = VW + 3;
   localparam int DW  = AW + FRAC_BITS + 2;
   localparam int QW  = (DW > COEF_W) ? DW : COEF_W;
   localparam int RW  = VW + 2;
   localparam int MCW = $clog2(FW);

   // configuration
   logic [IDS_W-1:0]              ids_ff;
   logic [2:0][SIZE_BITS-1:0]     size_ff;
   logic [2:0][COEF_W-1:0]        limit_ff;

   // sample and fit state
   logic [2:0][TIME_BITS-1:0]     time_ff, time_in;
   logic [1:0]                    count_ff, count_in;
   logic                          fitok_ff, fitok_in;
   logic [2:0][COEF_W-1:0]        coef_ff, coef_in;

   // sequencer
   state_type                     state_ff, state_in;
   logic [3:0]                    term_ff, term_in;
   logic [1:0]                    fidx_ff, fidx_in;
   logic [1:0]                    cidx_ff, cidx_in;
   logic [VW-1:0]                 val_ff, val_in;
   logic [VW-1:0]                 prod_ff, prod_in;
   logic [VW-1:0]                 mcand_ff, mcand_in;
   logic [FW-1:0]                 mplier_ff, mplier_in;
   logic [MCW-1:0]                cnt_ff, cnt_in;
   logic                          sign_ff, sign_in;
   logic signed [AW-1:0]          acc_ff, acc_in;
   logic [VW-1:0]                 den_ff, den_in;
   logic                          dneg_ff, dneg_in;
   logic                          nneg_ff, nneg_in;

   // response register
   logic                          rvalid_ff, rvalid_in;
   logic [1:0]                    rcode_ff, rcode_in;
   logic [2:0][COEF_W-1:0]        rfit_ff, rfit_in;

   // combinational helpers
   logic [TEST_NUM_W-1:0]         tnum;
   logic [TIME_BITS+ELAPSED_W-1:0] time_wide;
   logic [SIZE_BITS+SIZE_FLD_W-1:0] size_wide;
   logic                          accept;
   logic                          found;
   logic                          degen;
   term_type                      ti;
   fcode_type                     fc;
   logic [SIZE_BITS-1:0]          fa, fb;
   logic                          fsum;
   logic [FW-1:0]                 fmag;
   logic                          fneg;
   logic [VW-1:0]                 prod_step;
   logic signed [AW-1:0]          term_ext;
   logic [AW-1:0]                 acc_mag;
   logic [QW-1:0]                 dividend;
   logic [RW-1:0]                 divisor;
   logic                          div_start;
   logic                          div_done;
   logic [QW-1:0]                 quot;
   logic [COEF_W-1:0]             sat;

   assign tnum       = req_tdata[TEST_NUM_W-1:0];
   assign time_wide  = {{TIME_BITS{1'b0}}, req_tdata[TEST_NUM_W +: ELAPSED_W]};
   assign size_wide  = {{SIZE_BITS{1'b0}}, csr_wdata[SIZE_FLD_W-1:0]};
   assign req_tready = (state_ff == ST_IDLE) && (!rvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign degen      = (size_ff[0] == size_ff[1]) || (size_ff[0] == size_ff[2]) ||
                       (size_ff[1] == size_ff[2]);
   assign ti         = term_info(term_ff);

   // pick the current factor and form its magnitude and sign
   always_comb begin
      case (fidx_ff)
         2'd0:    fc = ti.f0;
         2'd1:    fc = ti.f1;
         default: fc = ti.f2;
      endcase
      fa   = size_ff[0];
      fb   = size_ff[1];
      fsum = 1'b0;
      case (fc)
         FC_D01:  begin fa = size_ff[0]; fb = size_ff[1]; end
         FC_D02:  begin fa = size_ff[0]; fb = size_ff[2]; end
         FC_D12:  begin fa = size_ff[1]; fb = size_ff[2]; end
         FC_S01:  begin fa = size_ff[0]; fb = size_ff[1]; fsum = 1'b1; end
         FC_S02:  begin fa = size_ff[0]; fb = size_ff[2]; fsum = 1'b1; end
         FC_S12:  begin fa = size_ff[1]; fb = size_ff[2]; fsum = 1'b1; end
         FC_X0:   begin fa = size_ff[0]; fb = '0; fsum = 1'b1; end
         FC_X1:   begin fa = size_ff[1]; fb = '0; fsum = 1'b1; end
         FC_X2:   begin fa = size_ff[2]; fb = '0; fsum = 1'b1; end
         default: begin fa = '0; fb = '0; fsum = 1'b1; end
      endcase
      if (fsum) begin
         fneg = 1'b0;
         fmag = {1'b0, fa} + {1'b0, fb};
      end else begin
         fneg = fa < fb;
         fmag = fneg ? {1'b0, fb - fa} : {1'b0, fa - fb};
      end
   end

   assign prod_step = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign term_ext  = sign_ff ? -$signed({{(AW-VW){1'b0}}, val_ff})
                              :  $signed({{(AW-VW){1'b0}}, val_ff});
   assign acc_mag   = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign dividend  = ({{(QW-AW){1'b0}}, acc_mag} << (FRAC_BITS + 1)) +
                      {{(QW-VW){1'b0}}, den_ff};
   assign divisor   = {1'b0, den_ff, 1'b0};
   assign div_start = (state_ff == ST_DIVGO);

   // round-half-away quotient, saturated to the signed coefficient range
   always_comb begin
      if (nneg_ff ^ dneg_ff) begin
         sat = (|quot[QW-1:COEF_W-1]) ? SIGN_BIT : -{1'b0, quot[COEF_W-2:0]};
      end else begin
         sat = (|quot[QW-1:COEF_W-1]) ? ~SIGN_BIT : {1'b0, quot[COEF_W-2:0]};
      end
   end

   qflc_div #(.QW(QW), .RW(RW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      state_in  = state_ff;
      time_in   = time_ff;
      count_in  = count_ff;
      fitok_in  = fitok_ff;
      coef_in   = coef_ff;
      term_in   = term_ff;
      fidx_in   = fidx_ff;
      cidx_in   = cidx_ff;
      val_in    = val_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      sign_in   = sign_ff;
      acc_in    = acc_ff;
      den_in    = den_ff;
      dneg_in   = dneg_ff;
      nneg_in   = nneg_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rcode_in  = rcode_ff;
      rfit_in   = rfit_ff;
      found     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_RECORD) begin
                  // lowest matching slot only
                  for (int i = 0; i < 3; i++) begin
                     if (!found && ids_ff[i*TEST_NUM_W +: TEST_NUM_W] == tnum) begin
                        found      = 1'b1;
                        time_in[i] = time_wide[TIME_BITS-1:0];
                     end
                  end
                  if (found && count_ff != 2'd3) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff != 2'd3) begin
                  rvalid_in = 1'b1;
                  rcode_in  = VERDICT_NO_DATA;
                  rfit_in   = '0;
               end else if (fitok_ff) begin
                  state_in = ST_CMP;
               end else if (degen) begin
                  rvalid_in = 1'b1;
                  rcode_in  = VERDICT_DEGENERATE;
                  rfit_in   = '0;
               end else begin
                  term_in  = TERM_DEN;
                  cidx_in  = '0;
                  acc_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            val_in   = (ti.ysel == YSEL_ONE) ? VW'(1) :
                       {{(VW-TIME_BITS){1'b0}}, time_ff[ti.ysel]};
            sign_in  = ti.flip;
            fidx_in  = '0;
            state_in = ST_FACT;
         end
         ST_FACT: begin
            if (fidx_ff == ti.nfac) begin
               state_in = ST_ACCUM;
            end else begin
               mcand_in  = val_ff;
               prod_in   = '0;
               mplier_in = fmag;
               sign_in   = sign_ff ^ fneg;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in   = prod_step;
            mcand_in  = {mcand_ff[VW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[FW-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == MCW'(FW - 1)) begin
               val_in   = prod_step;
               fidx_in  = fidx_ff + 1'b1;
               state_in = ST_FACT;
            end
         end
         ST_ACCUM: begin
            if (term_ff == TERM_DEN) begin
               den_in   = val_ff;
               dneg_in  = sign_ff;
               term_in  = term_ff + 1'b1;
               state_in = ST_LOAD;
            end else begin
               acc_in = acc_ff + term_ext;
               if (term_ff == TERM_SQ_LAST || term_ff == TERM_LIN_LAST ||
                   term_ff == TERM_CONST_LAST) begin
                  state_in = ST_DIVGO;
               end else begin
                  term_in  = term_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DIVGO: begin
            nneg_in  = acc_ff[AW-1];
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               coef_in[cidx_ff] = sat;
               cidx_in          = cidx_ff + 1'b1;
               acc_in           = '0;
               if (term_ff == TERM_CONST_LAST) begin
                  fitok_in = 1'b1;
                  state_in = ST_CMP;
               end else begin
                  term_in  = term_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_CMP: begin
            rvalid_in = 1'b1;
            rcode_in  = limit_exceeded(coef_ff, limit_ff) ? VERDICT_EXCEEDED
                                                          : VERDICT_WITHIN;
            rfit_in   = coef_ff;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         count_ff <= '0;
         fitok_ff <= 1'b0;
         coef_ff  <= '0;
      end else begin
         time_ff  <= time_in;
         count_ff <= count_in;
         fitok_ff <= fitok_in;
         coef_ff  <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      fidx_ff   <= fidx_in;
      cidx_ff   <= cidx_in;
      val_ff    <= val_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      sign_ff   <= sign_in;
      acc_ff    <= acc_in;
      den_ff    <= den_in;
      dneg_ff   <= dneg_in;
      nneg_ff   <= nneg_in;
      rcode_ff  <= rcode_in;
      rfit_ff   <= rfit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff   <= '0;
         size_ff  <= {SIZE_BITS'(2), SIZE_BITS'(1), SIZE_BITS'(0)};
         limit_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_TEST_IDS:    ids_ff      <= csr_wdata[IDS_W-1:0];
            REG_SIZE_A:      size_ff[0]  <= size_wide[SIZE_BITS-1:0];
            REG_SIZE_B:      size_ff[1]  <= size_wide[SIZE_BITS-1:0];
            REG_SIZE_C:      size_ff[2]  <= size_wide[SIZE_BITS-1:0];
            REG_LIMIT_SQ:    limit_ff[0] <= csr_wdata;
            REG_LIMIT_LIN:   limit_ff[1] <= csr_wdata;
            REG_LIMIT_CONST: limit_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rcode_ff;
   assign rsp_tdata  = {rfit_ff[2], rfit_ff[1], rfit_ff[0]};

endmodule

// ----- hw/rtl/qflc_checker.sv -----
// Port-level checks of the quadratic fit limit checker, bound to the top level.
// Depends on qflc_pkg and quadratic_fit_limit_check_macros.svh.
`timescale 1ns / 1ps
`include "quadratic_fit_limit_check_macros.svh"

module qflc_checker
   import qflc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   `QFLC_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid, "response after reset")
   `QFLC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response dropped")
   `QFLC_ASSERT(a_zero_fit, rsp_tvalid && (rsp_tuser == VERDICT_NO_DATA || rsp_tuser == VERDICT_DEGENERATE) |-> rsp_tdata == '0, "nonzero fit without fit")
   `QFLC_ASSERT(a_record_silent, req_tvalid && req_tready && req_tuser == OP_RECORD && !rsp_tvalid |=> !rsp_tvalid, "record made a word")
   `QFLC_ASSERT(a_no_overrun, req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready, "word taken over held response")

endmodule

bind quadratic_fit_limit_check qflc_checker u_qflc_checker (.*);

// ----- tb/quadratic_fit_limit_check_checker.sv -----
// Checker for quadratic_fit_limit_check: watches request, response and csr ports,
// predicts each verdict word and compares it field by field. Depends on qflc_pkg.
`timescale 1ns / 1ps

module quadratic_fit_limit_check_checker
   import qflc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending,
   output int                    checked,
   output logic [2:0][COEF_W-1:0] cached_fit
);

   typedef struct {
      verdict_type        code;
      logic [COEF_W-1:0]  coef [3];
   } verdict_word_type;

   verdict_word_type verdicts_due[$];

   logic [IDS_W-1:0]      ids;
   logic [SIZE_FLD_W-1:0] sizes [3];
   logic [COEF_W-1:0]     lims [3];
   logic [ELAPSED_W-1:0]  times [3];
   logic [1:0]            hits;
   logic                  fit_ok;

   // round(num * 2^32 / den), halves away from zero, saturated
   function automatic logic [COEF_W-1:0] fixed_quot(input logic signed [255:0] num,
                                                    input logic signed [255:0] den);
      logic [255:0] an;
      logic [255:0] ad;
      logic [255:0] q;
      logic         neg;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = ((an << (FRAC_BITS_DEF + 1)) + ad) / (ad << 1);
      if (|q[255:63])
         return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -q[63:0] : q[63:0];
   endfunction

   function automatic void fit_quadratic();
      logic signed [255:0] x0, x1, x2, y0, y1, y2, den, nsq, nlin, ncon;
      x0 = sizes[0]; x1 = sizes[1]; x2 = sizes[2];
      y0 = times[0]; y1 = times[1]; y2 = times[2];
      den  = (x0 - x1) * (x0 - x2) * (x1 - x2);
      nsq  = y0 * (x1 - x2) - y1 * (x0 - x2) + y2 * (x0 - x1);
      nlin = -y0 * (x1 - x2) * (x1 + x2) + y1 * (x0 - x2) * (x0 + x2)
             - y2 * (x0 - x1) * (x0 + x1);
      ncon = y0 * (x1 - x2) * x1 * x2 - y1 * (x0 - x2) * x0 * x2
             + y2 * (x0 - x1) * x0 * x1;
      cached_fit[0] = fixed_quot(nsq, den);
      cached_fit[1] = fixed_quot(nlin, den);
      cached_fit[2] = fixed_quot(ncon, den);
   endfunction

   function automatic logic over_limit();
      logic [COEF_W-1:0] fu, lu;
      for (int k = 0; k < 3; k++) begin
         fu = cached_fit[k] ^ SIGN_BIT;
         lu = lims[k] ^ SIGN_BIT;
         if (fu > lu && fu - lu > TOL_LSB) return 1'b1;
         if (lu > fu && lu - fu > TOL_LSB) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic verdict_word_type judge();
      verdict_word_type w;
      w.code = VERDICT_NO_DATA;
      for (int k = 0; k < 3; k++) w.coef[k] = '0;
      if (hits < 2'd3) return w;
      if (!fit_ok) begin
         if (sizes[0] == sizes[1] || sizes[0] == sizes[2] || sizes[1] == sizes[2]) begin
            w.code = VERDICT_DEGENERATE;
            return w;
         end
         fit_quadratic();
         fit_ok = 1'b1;
      end
      w.code = over_limit() ? VERDICT_EXCEEDED : VERDICT_WITHIN;
      for (int k = 0; k < 3; k++) w.coef[k] = cached_fit[k];
      return w;
   endfunction

   always @(posedge clock) begin
      verdict_word_type w;
      logic [TEST_NUM_W-1:0] tn;
      logic bad;
      if (reset) begin
         ids = '0;
         sizes[0] = 20'd0; sizes[1] = 20'd1; sizes[2] = 20'd2;
         for (int k = 0; k < 3; k++) begin
            lims[k] = '0; times[k] = '0; cached_fit[k] = '0;
         end
         hits = 2'd0;
         fit_ok = 1'b0;
         verdicts_due.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               REG_TEST_IDS:    ids = csr_wdata[IDS_W-1:0];
               REG_SIZE_A:      sizes[0] = csr_wdata[SIZE_FLD_W-1:0];
               REG_SIZE_B:      sizes[1] = csr_wdata[SIZE_FLD_W-1:0];
               REG_SIZE_C:      sizes[2] = csr_wdata[SIZE_FLD_W-1:0];
               REG_LIMIT_SQ:    lims[0] = csr_wdata;
               REG_LIMIT_LIN:   lims[1] = csr_wdata;
               REG_LIMIT_CONST: lims[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (verdicts_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected verdict word, code %0d", rsp_tuser);
            end else begin
               w = verdicts_due.pop_front();
               bad = rsp_tuser != w.code;
               for (int k = 0; k < 3; k++)
                  if (rsp_tdata[k*COEF_W +: COEF_W] != w.coef[k]) bad = 1'b1;
               if (bad) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %0d %h %h %h, got %0d %h %h %h",
                              w.code, w.coef[0], w.coef[1], w.coef[2], rsp_tuser,
                              rsp_tdata[63:0], rsp_tdata[127:64], rsp_tdata[191:128]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_RECORD) begin
               tn = req_tdata[TEST_NUM_W-1:0];
               for (int i = 0; i < 3; i++) begin
                  if (ids[16*i +: 16] == tn) begin
                     times[i] = req_tdata[TEST_NUM_W +: ELAPSED_W];
                     if (hits < 2'd3) hits++;
                     break;
                  end
               end
            end else begin
               verdicts_due.push_back(judge());
            end
         end
      end
      pending = verdicts_due.size();
   end

endmodule

// ----- tb/tb_quadratic_fit_limit_check.sv -----
// Top of the quadratic_fit_limit_check testbench: clock, reset, directed and random
// stimulus, csr phases and verdict. Depends on qflc_pkg, the design and the checker module.
`timescale 1ns / 1ps

module tb_quadratic_fit_limit_check;
   import qflc_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // test_number, elapsed_time, zero pad
   logic                  req_tuser;   // op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // fit_sq, fit_lin, fit_const
   logic [1:0]            rsp_tuser;   // verdict_code
   logic                  csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int errors, pending, checked;
   logic [2:0][COEF_W-1:0] cached_fit;
   logic quiet;
   int records_sent, verdicts_sent;
   logic [IDS_W-1:0] cur_ids;

   quadratic_fit_limit_check dut (.*);

   quadratic_fit_limit_check_checker u_checker (.*);

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   always @(negedge clock)
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == REG_TEST_IDS) cur_ids = val[IDS_W-1:0];
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // hold the word until accepted, then maybe leave a gap
   task automatic send_word(input logic op, input logic [15:0] tn, input logic [19:0] et);
      logic taken;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, et, tn};
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
      end
      if (op == OP_RECORD) records_sent++; else verdicts_sent++;
      if (!quiet && $urandom_range(99) < 24) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   task automatic drain(input int tail);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_limit(input logic [COEF_W-1:0] fit);
      case ($urandom_range(3))
         0: return fit + 64'($signed($urandom_range(12)) - 6);
         1: return {$urandom, $urandom};
         2: return 64'h8000_0000_0000_0000;
         default: return 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
   endfunction

   function automatic logic [19:0] pick_time();
      case ($urandom_range(5))
         0: return 20'd0;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] tn;
      quiet = 1'b0;
      records_sent = 0;
      verdicts_sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_RECORD;
      csr_wen = 1'b0;
      csr_addr = REG_TEST_IDS;
      csr_wdata = '0;
      cur_ids = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two slots share an id, equal sizes: not enough data, then degenerate
      csr_write(REG_TEST_IDS, {16'd9, 16'd7, 16'd7});
      csr_write(REG_SIZE_A, 64'd5);
      csr_write(REG_SIZE_B, 64'd5);
      csr_done();
      send_word(OP_VERDICT, 16'hFFFF, 20'hFFFFF);
      send_word(OP_RECORD, 16'd7, 20'hFFFFF);
      send_word(OP_VERDICT, 16'd0, 20'd0);
      send_word(OP_RECORD, 16'hFFFF, 20'd123);
      send_word(OP_RECORD, 16'd9, 20'd0);
      send_word(OP_VERDICT, 16'd0, 20'd0);
      send_word(OP_RECORD, 16'd7, 20'd77);
      send_word(OP_RECORD, 16'd9, 20'd5);
      send_word(OP_RECORD, 16'd7, 20'hFFFFF);
      send_word(OP_VERDICT, 16'd0, 20'd0);
      send_word(OP_VERDICT, 16'd0, 20'd0);
      drain(1000);

      // distinct extreme sizes: first real fit, cached from here on
      csr_write(REG_TEST_IDS, {16'hFFFF, 16'd0, 16'd7});
      csr_write(REG_SIZE_A, 64'd0);
      csr_write(REG_SIZE_B, 64'hFFFFF);
      csr_write(REG_SIZE_C, 64'd1 + $urandom_range(20'hFFFFD));
      csr_write(REG_LIMIT_SQ, 64'h7FFF_FFFF_FFFF_FFFF);
      csr_write(REG_LIMIT_LIN, 64'h8000_0000_0000_0000);
      csr_write(REG_LIMIT_CONST, 64'd0);
      csr_done();
      send_word(OP_RECORD, 16'd0, 20'hFFFFF);
      send_word(OP_RECORD, 16'hFFFF, 20'd0);
      send_word(OP_RECORD, 16'd7, pick_time());
      send_word(OP_VERDICT, 16'd0, 20'd0);
      send_word(OP_VERDICT, 16'd0, 20'd0);
      drain(1000);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: csr_write(REG_TEST_IDS, 64'hFFFF_FFFF_FFFF);
            1: csr_write(REG_TEST_IDS, 64'd0);
            default: csr_write(REG_TEST_IDS, {$urandom, $urandom});
         endcase
         csr_write(REG_SIZE_A, p[0] ? 64'hFFFFF : 64'($urandom));
         csr_write(REG_SIZE_B, 64'($urandom));
         csr_write(REG_SIZE_C, p[0] ? 64'd0 : 64'($urandom));
         csr_write(REG_LIMIT_SQ, pick_limit(cached_fit[0]));
         csr_write(REG_LIMIT_LIN, pick_limit(cached_fit[1]));
         csr_write(REG_LIMIT_CONST, pick_limit(cached_fit[2]));
         csr_done();
         quiet = (p == 5);
         for (int n = 0; n < 68; n++) begin
            if (p == 3 && n == 34) drain(0);
            if ($urandom_range(99) < 70) begin
               tn = $urandom_range(1) ? cur_ids[16*$urandom_range(2) +: 16]
                                      : 16'($urandom);
               send_word(OP_RECORD, tn, pick_time());
            end else begin
               send_word(OP_VERDICT, 16'($urandom), 20'($urandom));
            end
         end
         drain(1000);
      end
      quiet = 1'b0;

      $display("sent %0d records and %0d verdict queries over 12 csr settings;",
               records_sent, verdicts_sent);
      $display("checked %0d verdict words, %0d mismatches", checked, errors);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
